### rtl/typed_io_op_dispatch_queue_macros.svh
// Assertion macros for the typed I/O operation dispatch queue.
`ifndef TYPED_IO_OP_DISPATCH_QUEUE_MACROS_SVH
`define TYPED_IO_OP_DISPATCH_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
// Condition that holds at every clock edge outside reset.
`define TIODQ_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("check failed");
// Condition that implies another in the same cycle.
`define TIODQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
// Condition that implies another in the following cycle.
`define TIODQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`else
`define TIODQ_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define TIODQ_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TIODQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/tiodq_pkg.sv
// Shared constants, types and helpers of the typed I/O operation dispatch queue.
package tiodq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_BITS    = 8;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   // Command codes.
   localparam logic [1:0] FUNC_PUSH     = 2'd0;
   localparam logic [1:0] FUNC_DISPATCH = 2'd1;
   localparam logic [1:0] FUNC_COMPLETE = 2'd2;

   // Operation types with special rules.
   localparam logic [1:0] TYPE_SEND       = 2'd0;
   localparam logic [1:0] TYPE_DISCONNECT = 2'd2;

   // Result status codes.
   localparam logic [2:0] STAT_OK          = 3'd0;
   localparam logic [2:0] STAT_EMPTY       = 3'd1;
   localparam logic [2:0] STAT_BUSY        = 3'd2;
   localparam logic [2:0] STAT_DISC_SEND   = 3'd3;
   localparam logic [2:0] STAT_NONE_FLIGHT = 3'd4;
   localparam logic [2:0] STAT_NOT_FLIGHT  = 3'd5;
   localparam logic [2:0] STAT_OVERFLOW    = 3'd6;

   typedef enum logic {
      S_IDLE,
      S_EVAL
   } state_type;

   // One queue entry as held in the memory.
   typedef struct packed {
      logic [1:0]          op_type;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   // One result word.
   typedef struct packed {
      logic                issued;
      logic [1:0]          issued_type;
      logic [TAG_BITS-1:0] issued_tag;
      logic [2:0]          status;
      logic                send_waiting;
   } rsp_type;

   // Queue bookkeeping, exposed to the top level for checking.
   typedef struct packed {
      logic [CNT_BITS-1:0] count;
      logic [CNT_BITS-1:0] sends;
      logic [3:0]          mask;
   } stat_type;

   // Circular pointer increment for any queue depth.
   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      logic [PTR_BITS-1:0] r;
      if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_BITS'(1);
      end
      return r;
   endfunction

endpackage

### rtl/typed_io_op_dispatch_queue.sv
// Typed I/O operation dispatch queue: top level with the result register.
//
// The req_ channel carries one command word: push an operation (type and
// tag) into a 16-entry FIFO, try to dispatch the head, or complete an
// in-flight type. Each accepted word produces exactly one result word on
// the rsp_ channel: issued flag, issued type and tag, a status code and
// whether a send still waits in the queue.
// A word is accepted in one cycle, evaluated in the next against the head
// entry read from the queue memory, and the result is registered before
// rsp_valid rises. One word is handled at a time: no new word is taken
// while the last one is being evaluated.
// The result register frees the evaluation side: a new word is taken while
// a result is being collected in the same cycle. If the receiver holds
// rsp_ready low, the result stays in place and req_ready stays low.
// Synchronous reset empties the queue, clears the in-flight mask and drops
// any pending result; the memory contents are not cleared.
module typed_io_op_dispatch_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_func,
   input  logic [1:0]                     req_op_type,
   input  logic [tiodq_pkg::TAG_BITS-1:0] req_op_tag,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_issued,
   output logic [1:0]                     rsp_issued_type,
   output logic [tiodq_pkg::TAG_BITS-1:0] rsp_issued_tag,
   output logic [2:0]                     rsp_status,
   output logic                           rsp_send_waiting
);

`include "typed_io_op_dispatch_queue_macros.svh"

   logic                rsp_valid_ff, rsp_valid_in;
   tiodq_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   tiodq_pkg::rsp_type  core_word;
   tiodq_pkg::stat_type stat;
   logic                out_free, core_load;
   logic                issue_load;

   assign out_free = !rsp_valid_ff || rsp_ready;

   tiodq_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_op_type (req_op_type),
      .req_op_tag  (req_op_tag),
      .out_free    (out_free),
      .rsp_load    (core_load),
      .rsp_word    (core_word),
      .stat        (stat)
   );

   // Result register: loaded by the core, cleared when the word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_word;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_issued       = rsp_data_ff.issued;
   assign rsp_issued_type  = rsp_data_ff.issued_type;
   assign rsp_issued_tag   = rsp_data_ff.issued_tag;
   assign rsp_status       = rsp_data_ff.status;
   assign rsp_send_waiting = rsp_data_ff.send_waiting;

   // A result that hands out an operation is being loaded.
   assign issue_load = core_load && core_word.issued;

   // Queued sends can never outnumber the queued operations.
   `TIODQ_ASSERT_ALWAYS(a_sends_in_queue, clock, reset, stat.sends <= stat.count)
   // The core only loads a result into an empty result register.
   `TIODQ_ASSERT_IMPL(a_load_free, clock, reset, core_load, !rsp_valid_ff)
   // One word at a time: no accept in the cycle after an accept.
   `TIODQ_ASSERT_NEXT(a_one_word, clock, reset, req_valid && req_ready, !req_ready)
   // An issued operation leaves its type marked as in flight.
   `TIODQ_ASSERT_NEXT(a_issue_mask, clock, reset, issue_load, stat.mask[rsp_issued_type])

endmodule

### rtl/tiodq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tiodq_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tiodq_core.sv
// Command sequencer: reads the queue memory, applies the dispatch rules and writes back.
module tiodq_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic [1:0]                    req_op_type,
   input  logic [tiodq_pkg::TAG_BITS-1:0] req_op_tag,
   input  logic                          out_free,
   output logic                          rsp_load,
   output tiodq_pkg::rsp_type            rsp_word,
   output tiodq_pkg::stat_type           stat
);

   localparam int PB = tiodq_pkg::PTR_BITS;
   localparam int CB = tiodq_pkg::CNT_BITS;
   localparam int EB = $bits(tiodq_pkg::entry_type);

   tiodq_pkg::state_type state_ff, state_in;
   logic [PB-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CB-1:0] count_ff, count_in, sends_ff, sends_in;
   logic [3:0]    mask_ff, mask_in;
   logic [1:0]    func_ff, func_in, type_ff, type_in;
   logic [tiodq_pkg::TAG_BITS-1:0] tag_ff, tag_in;

   logic                 rd_en, wr_en;
   logic [EB-1:0]        rd_raw;
   tiodq_pkg::entry_type head_entry, wr_entry;

   assign head_entry = tiodq_pkg::entry_type'(rd_raw);
   assign wr_entry   = '{op_type: type_ff, tag: tag_ff};

   // Queue storage: head is read on accept, tail written in the evaluate cycle.
   tiodq_ram #(
      .DEPTH (tiodq_pkg::QUEUE_DEPTH),
      .WIDTH (EB)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_raw)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tiodq_pkg::S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         sends_ff <= '0;
         mask_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         sends_ff <= sends_in;
         mask_ff  <= mask_in;
      end
   end

   // Latched command word.
   always_ff @(posedge clock) begin
      func_ff <= func_in;
      type_ff <= type_in;
      tag_ff  <= tag_in;
   end

   // Next state and result.
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      sends_in  = sends_ff;
      mask_in   = mask_ff;
      func_in   = func_ff;
      type_in   = type_ff;
      tag_in    = tag_ff;
      req_ready = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      rsp_load  = 1'b0;
      rsp_word  = '0;
      case (state_ff)
         tiodq_pkg::S_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               rd_en    = 1'b1;
               func_in  = req_func;
               type_in  = req_op_type;
               tag_in   = req_op_tag;
               state_in = tiodq_pkg::S_EVAL;
            end
         end
         tiodq_pkg::S_EVAL: begin
            rsp_load = 1'b1;
            state_in = tiodq_pkg::S_IDLE;
            case (func_ff)
               tiodq_pkg::FUNC_PUSH: begin
                  if (count_ff == CB'(tiodq_pkg::QUEUE_DEPTH)) begin
                     rsp_word.status = tiodq_pkg::STAT_OVERFLOW;
                  end else begin
                     wr_en    = 1'b1;
                     tail_in  = tiodq_pkg::next_ptr(tail_ff);
                     count_in = count_ff + CB'(1);
                     if (type_ff == tiodq_pkg::TYPE_SEND) begin
                        sends_in = sends_ff + CB'(1);
                     end
                  end
               end
               tiodq_pkg::FUNC_DISPATCH: begin
                  if (count_ff == '0) begin
                     rsp_word.status = tiodq_pkg::STAT_EMPTY;
                  end else if (mask_ff[head_entry.op_type]) begin
                     rsp_word.status = tiodq_pkg::STAT_BUSY;
                  end else if (head_entry.op_type == tiodq_pkg::TYPE_DISCONNECT &&
                               mask_ff[tiodq_pkg::TYPE_SEND]) begin
                     rsp_word.status = tiodq_pkg::STAT_DISC_SEND;
                  end else begin
                     rsp_word.issued      = 1'b1;
                     rsp_word.issued_type = head_entry.op_type;
                     rsp_word.issued_tag  = head_entry.tag;
                     mask_in[head_entry.op_type] = 1'b1;
                     head_in  = tiodq_pkg::next_ptr(head_ff);
                     count_in = count_ff - CB'(1);
                     if (head_entry.op_type == tiodq_pkg::TYPE_SEND && sends_ff != '0) begin
                        sends_in = sends_ff - CB'(1);
                     end
                  end
               end
               tiodq_pkg::FUNC_COMPLETE: begin
                  if (mask_ff == '0) begin
                     rsp_word.status = tiodq_pkg::STAT_NONE_FLIGHT;
                  end else if (!mask_ff[type_ff]) begin
                     rsp_word.status = tiodq_pkg::STAT_NOT_FLIGHT;
                  end else begin
                     mask_in[type_ff] = 1'b0;
                  end
               end
               default: begin
                  // Unused command code: the word is ignored.
                  rsp_word.status = tiodq_pkg::STAT_OK;
               end
            endcase
            rsp_word.send_waiting = (sends_in != '0);
         end
         default: begin
            state_in = tiodq_pkg::S_IDLE;
         end
      endcase
   end

   assign stat = '{count: count_ff, sends: sends_ff, mask: mask_ff};

endmodule
